@@ rtl/topic_assignment_resampler_macros.svh @@
// assertion macros for the topic assignment resampler
`ifndef TOPIC_ASSIGNMENT_RESAMPLER_MACROS_SVH
`define TOPIC_ASSIGNMENT_RESAMPLER_MACROS_SVH
// same-cycle implication, checked every edge outside reset
`define TAR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TAR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/tar_pkg.sv @@
// ----------------------------------------------------------------------------
// tar_pkg
// shared types and codes for the topic assignment resampler
// ----------------------------------------------------------------------------
`default_nettype none
package tar_pkg;
  typedef enum logic [2:0] {
    ACT_LOAD_TABLE = 3'd0,
    ACT_LOAD_PRIOR = 3'd1,
    ACT_LOAD_COUNT = 3'd2,
    ACT_RESAMPLE   = 3'd3,
    ACT_READ_COUNT = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WEIGH,
    ST_THRESH,
    ST_SELECT,
    ST_UPDATE,
    ST_OUT
  } state_t;

  localparam int REG_DET_MODE = 0;
  localparam int REG_TOPICS   = 1;
endpackage
`default_nettype wire

@@ rtl/topic_assignment_resampler.sv @@
// ----------------------------------------------------------------------------
// topic_assignment_resampler
// collapsed gibbs topic resampler for one token per transfer
// ----------------------------------------------------------------------------
// One input transfer carries one action and gives exactly one result transfer.
// Loads and reads pass from the idle accept through the fetch and output states.
// A resample walks the topics in use twice: a weigh pass that reads one table
// entry a cycle from the table ram and forms each weight through one shared
// multiplier/adder, then a select pass over the stored weights, with the idle
// accept, fetch, threshold, update and output states around them; when every
// weight is zero the select pass is skipped. The block holds the result while
// the output waits, and takes no new input until the result transfer has
// completed.
`default_nettype none
`include "topic_assignment_resampler_macros.svh"
module topic_assignment_resampler #(
  parameter int MAX_TOPICS  = 16,
  parameter int VOCAB_SIZE  = 1024,
  parameter int COUNT_WIDTH = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // apb configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // action[2:0] topic_index[6:3] word_index[16:7] load_value[36:17]
  // old_topic[40:37] random_draw[56:41], zero fill
  input  wire logic [63:0] s_tdata,
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // new_topic[3:0] count_value[23:4] zero_total[24], zero fill
  output logic [31:0]      m_tdata
);
  import tar_pkg::*;

  localparam int TW  = (MAX_TOPICS > 1) ? $clog2(MAX_TOPICS) : 1;
  localparam int VW  = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
  localparam int AW  = TW + VW;
  localparam int NW  = $clog2(MAX_TOPICS + 1);
  localparam int SW  = ((COUNT_WIDTH > 10) ? COUNT_WIDTH : 10) + 1;
  localparam int WW  = 16 + SW;
  localparam int TOW = WW + TW + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // configuration registers
  logic       det_mode;
  logic [4:0] topics_reg;
  wire cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      det_mode   <= 1'b0;
      topics_reg <= 5'd16;
    end else if (cfg_wr) begin
      if (paddr[2] == 1'(REG_TOPICS)) topics_reg <= pwdata[4:0];
      else                            det_mode   <= pwdata[0];
    end
  end
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == 1'(REG_TOPICS)) prdata[4:0] = topics_reg;
    else                            prdata[0]   = det_mode;
  end

  // clamp of topics in use
  logic [NW-1:0] n_act;
  always_comb begin
    if (topics_reg == 5'd0) n_act = NW'(1);
    else if (32'(topics_reg) > MAX_TOPICS) n_act = NW'(MAX_TOPICS);
    else n_act = NW'(topics_reg);
  end

  // captured item
  logic [2:0]       act;
  logic [TW-1:0]    tidx, oldt;
  logic [VW-1:0]    widx;
  logic [19:0]      lval;
  logic [15:0]      draw;

  // stores
  logic [COUNT_WIDTH-1:0] counts [MAX_TOPICS];
  logic [9:0]             priors [MAX_TOPICS];
  logic [WW-1:0]          wt     [MAX_TOPICS];

  state_t state, state_next;
  logic [NW-1:0]  k;
  logic [TW-1:0]  pick;
  logic [TOW-1:0] total, run, thr;
  logic [WW-1:0]  best;
  logic           found, zt;
  logic [3:0]     out_topic;
  logic [19:0]    out_count;

  // table ram, address walks topics during weigh pass
  logic          tab_we;
  logic [AW-1:0] tab_addr;
  logic [15:0]   tab_rd;
  tar_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_tab (
    .clk(clk), .we(tab_we), .addr(tab_addr), .wdata(lval[15:0]), .rdata(tab_rd)
  );
  assign tab_we = (state == ST_FETCH) && (act == ACT_LOAD_TABLE);
  always_comb begin
    if (state == ST_WEIGH) tab_addr = {k[TW-1:0], widx};
    else                   tab_addr = {tidx, widx};
  end

  // shared multiplier: entry of topic k-1 times its count plus prior
  logic [TW-1:0] km1;
  logic [SW-1:0] cp;
  logic [WW-1:0] prod;
  assign km1  = TW'(k - NW'(1));
  assign cp   = SW'(counts[km1]) + SW'(priors[km1]);
  assign prod = WW'(tab_rd) * WW'(cp);

  // 42x16 threshold as two narrow products
  logic [TOW-1:0] thr_calc;
  assign thr_calc = TOW'((total >> 16) * TOW'(draw))
                  + TOW'((TOW'(total[15:0]) * TOW'(draw)) >> 16);

  wire in_xfer  = s_tvalid && s_tready;
  wire out_xfer = m_tvalid && m_tready;
  wire k_last   = (k == n_act);
  // select pass visits topics 0 to n-1 only
  wire k_sel_last = (k == n_act - NW'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_xfer) state_next = ST_FETCH;
      ST_FETCH:  state_next = (act == ACT_RESAMPLE) ? ST_WEIGH : ST_OUT;
      ST_WEIGH:  if (k_last) state_next = ST_THRESH;
      ST_THRESH: state_next = (total == '0) ? ST_UPDATE : ST_SELECT;
      ST_SELECT: if (k_sel_last) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_OUT;
      ST_OUT:    if (out_xfer) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_OUT);
    m_tdata  = {7'd0, zt, out_count, out_topic};
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TOPICS; i++) counts[i] <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_xfer) begin
          act  <= s_tdata[2:0];
          tidx <= TW'(s_tdata[6:3]);
          widx <= VW'(s_tdata[16:7]);
          lval <= s_tdata[36:17];
          oldt <= TW'(s_tdata[40:37]);
          draw <= s_tdata[56:41];
        end
        ST_FETCH: begin
          out_topic <= 4'd0;
          out_count <= (act == ACT_READ_COUNT) ? 20'(counts[tidx]) : 20'd0;
          zt        <= 1'b0;
          k         <= '0;
          total     <= '0;
          run       <= '0;
          best      <= '0;
          pick      <= '0;
          found     <= 1'b0;
          case (act)
            ACT_LOAD_PRIOR: priors[tidx] <= lval[9:0];
            ACT_LOAD_COUNT: counts[tidx] <= COUNT_WIDTH'(lval);
            ACT_RESAMPLE:   if (counts[oldt] != '0) counts[oldt] <= counts[oldt] - 1'b1;
            default: ;
          endcase
        end
        ST_WEIGH: begin
          if (k != '0) begin
            wt[km1] <= prod;
            total   <= total + TOW'(prod);
          end
          k <= k + NW'(1);
        end
        ST_THRESH: begin
          thr  <= thr_calc;
          k    <= '0;
          pick <= (total == '0 || det_mode) ? '0 : TW'(n_act - NW'(1));
          zt   <= (total == '0);
        end
        ST_SELECT: begin
          if (det_mode) begin
            if (wt[k[TW-1:0]] > best) begin
              best <= wt[k[TW-1:0]];
              pick <= k[TW-1:0];
            end
          end else if (!found) begin
            run <= run + TOW'(wt[k[TW-1:0]]);
            if (run + TOW'(wt[k[TW-1:0]]) > thr) begin
              found <= 1'b1;
              pick  <= k[TW-1:0];
            end
          end
          k <= k + NW'(1);
        end
        ST_UPDATE: begin
          if (counts[pick] != CNT_MAX) begin
            counts[pick] <= counts[pick] + 1'b1;
            out_count    <= 20'(counts[pick] + 1'b1);
          end else begin
            out_count    <= 20'(counts[pick]);
          end
          out_topic <= 4'(pick);
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  // checks
  `TAR_ASSERT_IMP(a_no_overlap, clk, rst, m_tvalid, !s_tready, "ready while result pending")
  `TAR_ASSERT_NXT(a_in_to_fetch, clk, rst, in_xfer, state == ST_FETCH, "accept not followed by fetch")
  `TAR_ASSERT_IMP(a_zero_topic, clk, rst, m_tvalid && zt, out_topic == 4'd0, "zero total with non-zero topic")
endmodule
`default_nettype wire

@@ rtl/tar_ram.sv @@
// ----------------------------------------------------------------------------
// tar_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module tar_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the topic assignment resampler
// ----------------------------------------------------------------------------
// Loads the table, prior and count stores, then runs resample, read and load
// transfers through the stream ports. It goes through several register
// settings and several idling patterns on both sides. A scoreboard keeps its
// own copy of the stores and predicts each result in order. Resamples only
// use words whose table column has been written for every topic.
`default_nettype none
module tb_top;
  import tar_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  // scoreboard: mirror of the block's stores plus the queue of expected results
  class resample_scoreboard;
    bit [15:0] table_mem [16384];
    bit [9:0]  prior_mem [16];
    bit [19:0] count_mem [16];
    bit        det_mode;
    bit [4:0]  topics_reg;
    bit [24:0] expected_q [$];
    int        errors;
    int        resamples;
    int        zero_hits;
    int        checked;

    function new();
      topics_reg = 5'd16;
    endfunction

    function void set_reg(int idx, bit [31:0] v);
      if (idx == REG_DET_MODE) det_mode = v[0];
      else if (idx == REG_TOPICS) topics_reg = v[4:0];
    endfunction

    // one token: take it out of its old topic, weigh, pick, put it back
    function bit [24:0] resample_token(bit [9:0] word, bit [3:0] old_t, bit [15:0] draw);
      longint unsigned weight [16];
      longint unsigned total;
      longint unsigned run;
      longint unsigned best;
      longint unsigned thr;
      int              n;
      int              pick;
      bit              zt;
      n = (topics_reg == 0) ? 1 : (topics_reg > 16) ? 16 : topics_reg;
      total = 0;
      run = 0;
      best = 0;
      pick = 0;
      zt = 0;
      if (count_mem[old_t] != 0) count_mem[old_t]--;
      for (int k = 0; k < n; k++) begin
        weight[k] = longint'(table_mem[{k[3:0], word}]) *
                    (longint'(count_mem[k]) + longint'(prior_mem[k]));
        total += weight[k];
      end
      if (total == 0) begin
        zt = 1;
        zero_hits++;
      end else if (det_mode) begin
        for (int k = 0; k < n; k++)
          if (weight[k] > best) begin
            best = weight[k];
            pick = k;
          end
      end else begin
        thr = (total * draw) >> 16;
        pick = n - 1;
        for (int k = 0; k < n; k++) begin
          run += weight[k];
          if (run > thr) begin
            pick = k;
            break;
          end
        end
      end
      if (count_mem[pick] != 20'hFFFFF) count_mem[pick]++;
      return {zt, count_mem[pick], pick[3:0]};
    endfunction

    function void note_input(bit [63:0] d);
      action_t   act;
      bit [3:0]  topic;
      bit [9:0]  word;
      bit [19:0] val;
      bit [24:0] res;
      act   = action_t'(d[2:0]);
      topic = d[6:3];
      word  = d[16:7];
      val   = d[36:17];
      res   = '0;
      case (act)
        ACT_LOAD_TABLE: table_mem[{topic, word}] = val[15:0];
        ACT_LOAD_PRIOR: prior_mem[topic] = val[9:0];
        ACT_LOAD_COUNT: count_mem[topic] = val;
        ACT_RESAMPLE: begin
          res = resample_token(word, d[40:37], d[56:41]);
          resamples++;
        end
        ACT_READ_COUNT: res[23:4] = count_mem[topic];
        default: res = '0;
      endcase
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch @%0t: %s", $time, msg);
    endtask

    task check_result(bit [31:0] r);
      bit [24:0] e;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with nothing expected", r));
      end else begin
        e = expected_q.pop_front();
        checked++;
        if (r[3:0] != e[3:0])
          report($sformatf("new_topic %0d, expected %0d", r[3:0], e[3:0]));
        if (r[23:4] != e[23:4])
          report($sformatf("count_value %0d, expected %0d", r[23:4], e[23:4]));
        if (r[24] != e[24])
          report($sformatf("zero_total %0d, expected %0d", r[24], e[24]));
        if (r[31:25] != 0)
          report($sformatf("fill bits %h not zero", r[31:25]));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  // action[2:0] topic_index[6:3] word_index[16:7] load_value[36:17]
  // old_topic[40:37] random_draw[56:41], zero fill
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  // new_topic[3:0] count_value[23:4] zero_total[24], zero fill
  logic [31:0] m_tdata;

  resample_scoreboard sb;
  int send_idle_pct;   // chance per cycle that the sender holds back
  int recv_stall_pct;  // chance per cycle that the receiver stalls
  int quiet_cycles;

  // words whose table column is fully written; word 2 stays all zero at first
  int unsigned ready_words [8] = '{0, 1, 2, 3, 341, 512, 682, 1023};

  topic_assignment_resampler i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [63:0] pack_item(action_t act, bit [3:0] topic, bit [9:0] word,
                                            bit [19:0] val, bit [3:0] old_t, bit [15:0] draw);
    return {7'd0, draw, old_t, val, word, topic, act};
  endfunction

  // one input transfer, with random hold-off before it
  task send(logic [63:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(d);
  endtask

  task drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // apb write: setup cycle then access cycle
  task reg_write(int idx, bit [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  function automatic bit [19:0] rand_count();
    case ($urandom_range(9))
      0:       return 20'($urandom);
      1:       return 20'hFFFFF - 20'($urandom_range(3));
      default: return 20'($urandom_range(40));
    endcase
  endfunction

  // mostly resamples on written words, with loads, reads and unused codes mixed in
  function automatic logic [63:0] random_item();
    int        r;
    bit [9:0]  word;
    bit [19:0] val;
    r = $urandom_range(99);
    word = 10'(ready_words[$urandom_range(7)]);
    val = ($urandom_range(3) == 0) ? 20'd0 : 20'($urandom);
    if (r < 55)
      return pack_item(ACT_RESAMPLE, 4'($urandom), word, 20'($urandom),
                       4'($urandom), 16'($urandom));
    else if (r < 67)
      return pack_item(ACT_LOAD_TABLE, 4'($urandom),
                       $urandom_range(1) ? word : 10'($urandom), val,
                       4'($urandom), 16'($urandom));
    else if (r < 74)
      return pack_item(ACT_LOAD_PRIOR, 4'($urandom), 10'($urandom), 20'($urandom),
                       4'($urandom), 16'($urandom));
    else if (r < 84)
      return pack_item(ACT_LOAD_COUNT, 4'($urandom), 10'($urandom), rand_count(),
                       4'($urandom), 16'($urandom));
    else if (r < 95)
      return pack_item(ACT_READ_COUNT, 4'($urandom), 10'($urandom), 20'($urandom),
                       4'($urandom), 16'($urandom));
    else
      return {7'd0, 54'($urandom) << 3 | 54'({$urandom, $urandom}) << 35,
              3'($urandom_range(5, 7))} & 64'h01FF_FFFF_FFFF_FFFF;
  endfunction

  // receiver side: stall pattern, result check and watchdog in one place
  always @(posedge clk) begin
    if (rst) begin
      m_tready     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int det_set [9]    = '{0, 1, 0, 1, 0, 1, 0, 1, 0};
    int topics_set [9] = '{16, 16, 1, 1, 0, 31, 7, 12, 16};
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the prior store and the table columns of the working words
    for (int k = 0; k < 16; k++)
      send(pack_item(ACT_LOAD_PRIOR, 4'(k), '0, (k == 4) ? 20'hFFFFF : 20'($urandom),
                     '0, '0));
    for (int w = 0; w < 8; w++)
      for (int k = 0; k < 16; k++)
        send(pack_item(ACT_LOAD_TABLE, 4'(k), 10'(ready_words[w]),
                       (ready_words[w] == 2) ? 20'd0 : 20'($urandom), '0, '0));

    // directed part, highest-weight mode first, then draw mode
    drain();
    reg_write(REG_DET_MODE, 1);
    reg_write(REG_TOPICS, 16);
    send(pack_item(ACT_READ_COUNT, 4'd0, '0, '0, '0, '0));
    send(pack_item(ACT_RESAMPLE, 4'd0, 10'd2, '0, 4'd15, 16'hFFFF));  // all weights zero
    send(pack_item(ACT_RESAMPLE, 4'd0, 10'd0, '0, 4'd9, '0));         // old count already zero
    send(pack_item(ACT_LOAD_TABLE, 4'd3, 10'd0, 20'hFFFFF, '0, '0));
    send(pack_item(ACT_LOAD_COUNT, 4'd3, '0, 20'hFFFFF, '0, '0));
    send(pack_item(ACT_RESAMPLE, 4'd0, 10'd0, '0, 4'd3, '0));
    send(pack_item(ACT_RESAMPLE, 4'd0, 10'd0, '0, 4'd5, '0));         // count stays at max
    send(pack_item(ACT_READ_COUNT, 4'd3, '0, '0, '0, '0));
    send(pack_item(ACT_LOAD_COUNT, 4'd15, 10'h3FF, 20'hFFFFF, 4'hF, 16'hFFFF));
    send(pack_item(ACT_READ_COUNT, 4'd15, 10'h3FF, 20'hFFFFF, 4'hF, 16'hFFFF));
    send(pack_item(ACT_LOAD_COUNT, 4'd3, '0, 20'd5, '0, '0));
    send(64'h01FF_FFFF_FFFF_FFFD);                                    // unused codes
    send(64'h01FF_FFFF_FFFF_FFFE);
    send(64'h01FF_FFFF_FFFF_FFFF);
    drain();
    reg_write(REG_DET_MODE, 0);
    send(pack_item(ACT_RESAMPLE, 4'd0, 10'd1023, '0, 4'd15, 16'd0));
    send(pack_item(ACT_RESAMPLE, 4'd0, 10'd1023, '0, 4'd0, 16'hFFFF));
    send(pack_item(ACT_RESAMPLE, 4'd0, 10'd2, '0, 4'd0, 16'h8000));

    // random part: nine settings, three idling patterns
    for (int ph = 0; ph < 9; ph++) begin
      drain();
      reg_write(REG_DET_MODE, det_set[ph]);
      reg_write(REG_TOPICS, topics_set[ph]);
      send_idle_pct  = (ph < 3) ? 30 : (ph < 6) ? 87 : 0;
      recv_stall_pct = (ph < 3) ? 87 : (ph < 6) ? 30 : 0;
      for (int i = 0; i < 88; i++) begin
        // hold-off until the block has emptied, once
        if (ph == 4 && i == 50) drain();
        send(random_item());
      end
    end

    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d results, %0d resamples, %0d with all weights zero",
             sb.checked, sb.resamples, sb.zero_hits);
    $display("both modes, topic counts 0 to 31, three idling patterns on each side");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
